@@ rtl/dlce_pkg.sv @@
// Package for the debug link command engine.
// Command codes, store layout constants, item codes and a shared struct.
// No dependencies.
package dlce_pkg;

  // Pointer width: every command address stays below 592.
  localparam int PTR_W = 10;
  localparam int STORE_DEPTH_DEF = 1024;

  // Command bytes
  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] CMD_DUMP_LO  = 8'hFE;
  localparam logic [7:0] CMD_DUMP_HI  = 8'hFD;
  localparam logic [7:0] CMD_MON_LAST = 8'h13;
  localparam logic [7:0] GROUP_MASK   = 8'hC0;
  localparam logic [7:0] INDEX_MASK   = 8'h3F;

  // Command groups, bits [7:6] of the command byte
  localparam logic [1:0] GRP_STATE_RD = 2'b01;
  localparam logic [1:0] GRP_CAPTURE  = 2'b10;

  // Store layout
  localparam int DUMP_LO_BASE = 0;
  localparam int DUMP_HI_BASE = 128;
  localparam int DUMP_LEN     = 128;
  localparam int MON_BASE     = 256;
  localparam int STATE_BASE   = 336;
  localparam int WORD_LEN     = 4;

  typedef enum logic [1:0] {
    MODE_RX       = 2'd0,
    MODE_TX_READY = 2'd1,
    MODE_LOC_WR   = 2'd2,
    MODE_LOC_RD   = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_LINK  = 1'b0,
    KIND_LOCAL = 1'b1
  } kind_t;

  // Where the result byte comes from
  typedef enum logic [1:0] {
    SRC_MEM  = 2'd0,
    SRC_ECHO = 2'd1,
    SRC_ZERO = 2'd2
  } src_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  more;
    src_t  src;
  } out_meta_t;

endpackage

@@ rtl/debug_link_command_engine.sv @@
// Top level of the debug link command engine: stream ports, output stage.
// Instantiates dlce_ctrl and dlce_store; uses dlce_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------
//   s_*      | in        | s_tvalid / s_tready  | tuser: mode; tdata: rx_byte,
//            |           |                      |   local_addr, local_data
//   m_*      | out       | m_tvalid / m_tready  | tuser: kind; tdata: out_byte,
//            |           |                      |   more_pending
//
// One item is accepted per cycle while s_tready is high. Its result, if any, is
// presented on m_* in the cycle after acceptance; the register in between is the
// store's registered read port, which also serves as the output register.
// Reset clears the four pointers and the output valid; store contents are kept.
// While a result waits with m_tready low, s_tready is low and the store read
// data holds; s_tready returns in the cycle the result is taken.
module debug_link_command_engine #(
  parameter int STORE_DEPTH = dlce_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] rx_byte, [17:8] local_addr,
                                 // [25:18] local_data, [31:26] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] more_pending, [15:9] zero
  output logic        m_tuser    // [0] kind
);
  import dlce_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  out_meta_t     meta;
  out_meta_t     out_q;
  logic [7:0]    out_byte;

  // a pending result blocks new items only while it is not being taken
  assign s_tready = !out_q.valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  dlce_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode_t'(s_tuser)),
    .rx_byte    (s_tdata[7:0]),
    .local_addr (s_tdata[17:8]),
    .local_data (s_tdata[25:18]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .meta       (meta)
  );

  dlce_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output stage: result description; the byte itself sits in the store's
  // read register when it comes from memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q <= '{valid: 1'b0, kind: KIND_LINK, more: 1'b0, src: SRC_MEM};
    end else if (s_tready) begin
      out_q <= meta;
    end
  end

  always_comb begin
    case (out_q.src)
      SRC_MEM:  out_byte = mem_rdata;
      SRC_ECHO: out_byte = CMD_RESET;
      SRC_ZERO: out_byte = 8'h00;
      default:  out_byte = 8'h00;
    endcase
  end

  assign m_tvalid = out_q.valid;
  assign m_tdata  = {7'b0, out_q.more, out_byte};
  assign m_tuser  = out_q.kind;

  // A waiting result must block the input side.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while a result is stalled");

  // Local reads never claim further link bytes.
  a_local_no_more: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_q.kind == KIND_LOCAL) |-> !out_q.more)
    else $error("local read result with more_pending set");

  // The reset echo closes any read.
  a_echo_no_more: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_q.src == SRC_ECHO) |-> !out_q.more && (out_q.kind == KIND_LINK))
    else $error("reset echo with wrong kind or more_pending");

  // A result follows only an accepted item.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(m_tvalid) |-> $past(accept))
    else $error("result appeared without an accepted item");

endmodule

@@ rtl/dlce_store.sv @@
// Byte store of the debug link command engine.
// One write port, one read port with registered data. Uses dlce_pkg.
module dlce_store #(
  parameter int DEPTH = dlce_pkg::STORE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import dlce_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/dlce_ctrl.sv @@
// Command decode and pointer registers of the debug link command engine.
// Drives store accesses and the result description of each item. Uses dlce_pkg.
module dlce_ctrl #(
  parameter int STORE_DEPTH = dlce_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  dlce_pkg::mode_t     mode,
  input  logic [7:0]          rx_byte,
  input  logic [9:0]          local_addr,
  input  logic [7:0]          local_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  output dlce_pkg::out_meta_t meta
);
  import dlce_pkg::*;

  logic [PTR_W-1:0] read_position, read_position_next;
  logic [PTR_W-1:0] read_end, read_end_next;
  logic [PTR_W-1:0] write_position, write_position_next;
  logic [PTR_W-1:0] write_end, write_end_next;

  logic [1:0]       group;
  logic [PTR_W-1:0] word_off;
  logic [PTR_W-1:0] rp_inc;
  logic             local_in_range;

  assign group          = rx_byte[7:6];
  assign word_off       = PTR_W'({rx_byte & INDEX_MASK, 2'b00});
  assign rp_inc         = read_position + PTR_W'(1);
  assign local_in_range = 32'(local_addr) < 32'(STORE_DEPTH);

  always_comb begin
    read_position_next  = read_position;
    read_end_next       = read_end;
    write_position_next = write_position;
    write_end_next      = write_end;
    mem_we    = 1'b0;
    mem_waddr = AW'(write_position);
    mem_wdata = rx_byte;
    mem_re    = 1'b0;
    mem_raddr = AW'(read_position);
    meta      = '{valid: 1'b0, kind: KIND_LINK, more: 1'b0, src: SRC_MEM};
    if (accept) begin
      case (mode)
        MODE_RX: begin
          if (write_position != write_end) begin
            // capture open: store the byte while below the capture end
            if (write_position < write_end) begin
              mem_we              = 1'b1;
              write_position_next = write_position + PTR_W'(1);
            end
          end else if (rx_byte == CMD_RESET) begin
            read_position_next  = '0;
            read_end_next       = '0;
            write_position_next = '0;
            write_end_next      = '0;
            meta.valid = 1'b1;
            meta.src   = SRC_ECHO;
          end else if (rx_byte == CMD_DUMP_LO || rx_byte == CMD_DUMP_HI) begin
            mem_re     = 1'b1;
            meta.valid = 1'b1;
            meta.more  = 1'b1;
            if (rx_byte == CMD_DUMP_LO) begin
              mem_raddr          = AW'(DUMP_LO_BASE);
              read_position_next = PTR_W'(DUMP_LO_BASE + 1);
              read_end_next      = PTR_W'(DUMP_LO_BASE + DUMP_LEN);
            end else begin
              mem_raddr          = AW'(DUMP_HI_BASE);
              read_position_next = PTR_W'(DUMP_HI_BASE + 1);
              read_end_next      = PTR_W'(DUMP_HI_BASE + DUMP_LEN);
            end
          end else if (rx_byte <= CMD_MON_LAST) begin
            mem_re             = 1'b1;
            meta.valid         = 1'b1;
            meta.more          = 1'b1;
            mem_raddr          = AW'(PTR_W'(MON_BASE) + PTR_W'({rx_byte, 2'b00}));
            read_position_next = PTR_W'(MON_BASE + 1) + PTR_W'({rx_byte, 2'b00});
            read_end_next      = PTR_W'(MON_BASE + WORD_LEN) + PTR_W'({rx_byte, 2'b00});
          end else if (group == GRP_STATE_RD) begin
            mem_re             = 1'b1;
            meta.valid         = 1'b1;
            meta.more          = 1'b1;
            mem_raddr          = AW'(PTR_W'(STATE_BASE) + word_off);
            read_position_next = PTR_W'(STATE_BASE + 1) + word_off;
            read_end_next      = PTR_W'(STATE_BASE + WORD_LEN) + word_off;
          end else if (group == GRP_CAPTURE) begin
            write_position_next = PTR_W'(STATE_BASE) + word_off;
            write_end_next      = PTR_W'(STATE_BASE + WORD_LEN) + word_off;
          end
        end
        MODE_TX_READY: begin
          if (read_position < read_end) begin
            mem_re             = 1'b1;
            read_position_next = rp_inc;
            meta.valid         = 1'b1;
            meta.more          = rp_inc < read_end;
          end
        end
        MODE_LOC_WR: begin
          mem_we    = local_in_range;
          mem_waddr = AW'(local_addr);
          mem_wdata = local_data;
        end
        MODE_LOC_RD: begin
          mem_re     = local_in_range;
          mem_raddr  = AW'(local_addr);
          meta.valid = 1'b1;
          meta.kind  = KIND_LOCAL;
          meta.src   = local_in_range ? SRC_MEM : SRC_ZERO;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_position  <= '0;
      read_end       <= '0;
      write_position <= '0;
      write_end      <= '0;
    end else begin
      read_position  <= read_position_next;
      read_end       <= read_end_next;
      write_position <= write_position_next;
      write_end      <= write_end_next;
    end
  end

endmodule

@@ verif/debug_link_command_engine_test.sv @@
// Self-checking testbench for debug_link_command_engine: stream stimulus,
// a shadow model of the pointers and byte store, and a result checker.
// Depends on dlce_pkg and the RTL of the engine.
module debug_link_command_engine_test;
  import dlce_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIR        = 28;
  // end of the region any link command can read
  localparam int FILL_END     = STATE_BASE + 64 * WORD_LEN;

  // How a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT = 2'd0,  // shadow model decides
    CHK_NONE    = 2'd1,  // no result may come
    CHK_LINK    = 2'd2,  // link byte, nothing more pending
    CHK_LOCAL   = 2'd3   // local read data
  } chk_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       more;
  } link_result_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       rx;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
    chk_t             chk;
    logic [7:0]       eb;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  // Check mode travelling with the item currently on the slave side
  chk_t        item_chk = CHK_PREDICT;
  logic [7:0]  item_byte = '0;

  int tx_idle_pct = 35;
  int rx_idle_pct = 75;
  int errors = 0;
  int stall_cycles = 0;
  int effective_items = 0;

  // Shadow state of the engine
  logic [7:0]       shadow_mem [STORE_DEPTH_DEF];
  bit               written [STORE_DEPTH_DEF];
  logic [PTR_W-1:0] rd_ptr = '0, rd_stop = '0, wr_ptr = '0, wr_stop = '0;

  link_result_t due_results [$];
  stim_row_t    dir_tab [N_DIR];

  debug_link_command_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------- shadow model

  function automatic bit next_tx(output link_result_t r);
    r = '0;
    if (rd_ptr >= rd_stop) return 1'b0;
    r.kind      = KIND_LINK;
    r.data_byte = shadow_mem[rd_ptr];
    rd_ptr      = rd_ptr + 1'b1;
    r.more      = (rd_ptr < rd_stop);
    return 1'b1;
  endfunction

  function automatic bit begin_read(input logic [PTR_W-1:0] start,
                                    input logic [PTR_W-1:0] len,
                                    output link_result_t r);
    rd_ptr  = start;
    rd_stop = start + len;
    return next_tx(r);
  endfunction

  // Applies one item; returns 1 unless the item is ignored outright.
  function automatic bit engine_step(input mode_t m, input logic [7:0] rx,
                                     input logic [PTR_W-1:0] a, input logic [7:0] d,
                                     output bit hit, output link_result_t r);
    hit = 1'b0;
    r   = '0;
    case (m)
      MODE_RX: begin
        if (wr_ptr != wr_stop) begin
          // capture open: byte goes to the store, never decoded
          if (wr_ptr < wr_stop) begin
            shadow_mem[wr_ptr] = rx;
            written[wr_ptr] = 1'b1;
            wr_ptr = wr_ptr + 1'b1;
          end
        end else if (rx == CMD_RESET) begin
          rd_ptr = '0; rd_stop = '0; wr_ptr = '0; wr_stop = '0;
          hit = 1'b1;
          r   = '{kind: KIND_LINK, data_byte: CMD_RESET, more: 1'b0};
        end else if (rx == CMD_DUMP_LO) begin
          hit = begin_read(PTR_W'(DUMP_LO_BASE), PTR_W'(DUMP_LEN), r);
        end else if (rx == CMD_DUMP_HI) begin
          hit = begin_read(PTR_W'(DUMP_HI_BASE), PTR_W'(DUMP_LEN), r);
        end else if (rx <= CMD_MON_LAST) begin
          hit = begin_read(PTR_W'(MON_BASE + rx * WORD_LEN), PTR_W'(WORD_LEN), r);
        end else if (rx[7:6] == GRP_STATE_RD) begin
          hit = begin_read(PTR_W'(STATE_BASE + (rx & INDEX_MASK) * WORD_LEN),
                           PTR_W'(WORD_LEN), r);
        end else if (rx[7:6] == GRP_CAPTURE) begin
          wr_ptr  = PTR_W'(STATE_BASE + (rx & INDEX_MASK) * WORD_LEN);
          wr_stop = wr_ptr + PTR_W'(WORD_LEN);
        end else begin
          return 1'b0;
        end
        return 1'b1;
      end
      MODE_TX_READY: begin
        hit = next_tx(r);
        return hit;
      end
      MODE_LOC_WR: begin
        shadow_mem[a] = d;
        written[a] = 1'b1;
        return 1'b1;
      end
      default: begin
        hit = 1'b1;
        r   = '{kind: KIND_LOCAL, data_byte: shadow_mem[a], more: 1'b0};
        return 1'b1;
      end
    endcase
  endfunction

  // Local reads only go to bytes that hold a value
  function automatic logic [PTR_W-1:0] pick_read_addr();
    logic [PTR_W-1:0] a;
    a = PTR_W'($urandom);
    if (!written[a]) a = PTR_W'($urandom_range(FILL_END - 1));
    return a;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    link_result_t want, pred;
    bit           hit;
    bit           in_go, out_go;
    in_go  = !rst && s_tvalid && s_tready;
    out_go = !rst && m_tvalid && m_tready;
    if (out_go) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %b byte %h more %b",
                 $time, m_tuser, m_tdata[7:0], m_tdata[8]);
        errors++;
      end else begin
        want = due_results.pop_front();
        report_field("kind", 8'(want.kind), 8'(m_tuser));
        report_field("out_byte", want.data_byte, m_tdata[7:0]);
        report_field("more_pending", 8'(want.more), 8'(m_tdata[8]));
      end
    end
    if (in_go) begin
      if (engine_step(mode_t'(s_tuser), s_tdata[7:0], s_tdata[17:8], s_tdata[25:18],
                      hit, pred))
        effective_items++;
      case (item_chk)
        CHK_PREDICT: if (hit) due_results.push_back(pred);
        CHK_LINK:    due_results.push_back('{kind: KIND_LINK, data_byte: item_byte,
                                             more: 1'b0});
        CHK_LOCAL:   due_results.push_back('{kind: KIND_LOCAL, data_byte: item_byte,
                                             more: 1'b0});
        default: ;
      endcase
    end
    if (in_go || out_go) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic stim_row_t row(input mode_t m, input logic [7:0] v,
                                    input logic [PTR_W-1:0] a, input logic [7:0] d,
                                    input chk_t c, input logic [7:0] eb);
    return '{mode: m, rx: v, addr: a, data: d, chk: c, eb: eb};
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input mode_t m, input logic [7:0] rx, input logic [PTR_W-1:0] a,
                      input logic [7:0] d, input chk_t c = CHK_PREDICT,
                      input logic [7:0] eb = 8'h00);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= m;
    s_tdata   <= {6'b0, d, a, rx};
    item_chk  <= c;
    item_byte <= eb;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int          sel, k, idx, base, target;
    logic [7:0]  cmd;
    mode_t       rmode;

    dir_tab = '{
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_NONE,    8'h00),  // idle link
      row(MODE_RX,       8'hFF, 10'd0,    8'h00, CHK_LINK,    8'hFF),  // reset echo
      row(MODE_LOC_WR,   8'h00, 10'd1023, 8'hFF, CHK_NONE,    8'h00),
      row(MODE_LOC_RD,   8'h00, 10'd1023, 8'h00, CHK_LOCAL,   8'hFF),
      row(MODE_LOC_WR,   8'h00, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_LOC_RD,   8'h00, 10'd0,    8'h00, CHK_LOCAL,   8'h00),
      row(MODE_RX,       8'h00, 10'd0,    8'h00, CHK_PREDICT, 8'h00),  // first monitor word
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_NONE,    8'h00),  // word drained
      row(MODE_RX,       8'h13, 10'd0,    8'h00, CHK_PREDICT, 8'h00),  // last monitor word
      row(MODE_RX,       8'h40, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_RX,       8'h7F, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_RX,       8'h80, 10'd0,    8'h00, CHK_NONE,    8'h00),  // open capture
      row(MODE_RX,       8'hA5, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'h5A, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'hFF, 10'd0,    8'h00, CHK_NONE,    8'h00),  // stored, not decoded
      row(MODE_RX,       8'h00, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'h40, 10'd0,    8'h00, CHK_PREDICT, 8'h00),  // read capture back
      row(MODE_RX,       8'h14, 10'd0,    8'h00, CHK_NONE,    8'h00),  // unused codes
      row(MODE_RX,       8'hFC, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'hC0, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'hFE, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_RX,       8'hFD, 10'd0,    8'h00, CHK_PREDICT, 8'h00),
      row(MODE_RX,       8'hFF, 10'd0,    8'h00, CHK_LINK,    8'hFF),  // reset mid-dump
      row(MODE_TX_READY, 8'h00, 10'd0,    8'h00, CHK_NONE,    8'h00),
      row(MODE_RX,       8'hBF, 10'd0,    8'h00, CHK_NONE,    8'h00)   // top capture slot
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill every byte a link command can reach so no read hits an unwritten byte
    for (int a = 0; a < FILL_END; a++)
      send(MODE_LOC_WR, 8'($urandom), PTR_W'(a), 8'($urandom));

    foreach (dir_tab[i])
      send(dir_tab[i].mode, dir_tab[i].rx, dir_tab[i].addr, dir_tab[i].data,
           dir_tab[i].chk, dir_tab[i].eb);

    // Random part in three idling phases
    base = effective_items;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 75 : 0;
      rx_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 35 : 0;
      target = base + (ph + 1) * RANDOM_ITEMS / 3;
      while (effective_items < target) begin
        sel = $urandom_range(99);
        if (sel < 25) begin
          // word read, drained partly or fully
          if ($urandom_range(1)) cmd = 8'($urandom_range(CMD_MON_LAST));
          else cmd = {GRP_STATE_RD, 6'($urandom)};
          send(MODE_RX, cmd, PTR_W'($urandom), 8'($urandom));
          k = $urandom_range(WORD_LEN);
          repeat (k) send(MODE_TX_READY, 8'($urandom), PTR_W'($urandom), 8'($urandom));
        end else if (sel < 28) begin
          cmd = $urandom_range(1) ? CMD_DUMP_LO : CMD_DUMP_HI;
          send(MODE_RX, cmd, PTR_W'($urandom), 8'($urandom));
          k = $urandom_range(DUMP_LEN);
          repeat (k) send(MODE_TX_READY, 8'($urandom), PTR_W'($urandom), 8'($urandom));
        end else if (sel < 48) begin
          // capture, now and then cut short, often read back
          idx = $urandom_range(63);
          send(MODE_RX, {GRP_CAPTURE, 6'(idx)}, PTR_W'($urandom), 8'($urandom));
          k = ($urandom_range(9) == 0) ? $urandom_range(3) : WORD_LEN;
          repeat (k) send(MODE_RX, 8'($urandom), PTR_W'($urandom), 8'($urandom));
          if ($urandom_range(1))
            send(MODE_RX, {GRP_STATE_RD, 6'(idx)}, PTR_W'($urandom), 8'($urandom));
        end else if (sel < 60) begin
          send(MODE_LOC_WR, 8'($urandom), PTR_W'($urandom), 8'($urandom));
        end else if (sel < 72) begin
          send(MODE_LOC_RD, 8'($urandom), pick_read_addr(), 8'($urandom));
        end else if (sel < 76) begin
          send(MODE_RX, CMD_RESET, PTR_W'($urandom), 8'($urandom));
        end else if (sel < 86) begin
          send(MODE_TX_READY, 8'($urandom), PTR_W'($urandom), 8'($urandom));
        end else begin
          rmode = mode_t'($urandom_range(3));
          send(rmode, 8'($urandom),
               (rmode == MODE_LOC_RD) ? pick_read_addr() : PTR_W'($urandom),
               8'($urandom));
        end
      end
    end

    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
